/* rtl/core/arpc_pkg.sv */
// arpc_pkg: shared types and codes for the address resolution cache
// used by arpc_cell, arp_cache_with_aging_top and arpc_checker; no dependencies
package arpc_pkg;

  localparam int SLOT_W = 8;   // slot number, covers up to 256 entries
  localparam int CNT_W  = 5;

  localparam logic [7:0] AGE_LIMIT_RST = 8'd30;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] RES_INSERTED = 3'd0;
  localparam logic [2:0] RES_PRESENT  = 3'd1;
  localparam logic [2:0] RES_FULL     = 3'd2;
  localparam logic [2:0] RES_HIT      = 3'd3;
  localparam logic [2:0] RES_MISS     = 3'd4;
  localparam logic [2:0] RES_TICKED   = 3'd5;

  // operation token walking the row of cells
  typedef struct packed {
    logic              valid;
    logic [1:0]        op;
    logic [31:0]       ip;
    logic [47:0]       mac;
    logic              found;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic [CNT_W-1:0]  removed;
  } tok_t;

  // broadcast write of a new entry once the token has left the row
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       ip;
    logic [47:0]       mac;
  } wr_t;

endpackage

/* rtl/core/arpc_cell.sv */
// arpc_cell: one cache entry plus one stage of the token chain
// depends on arpc_pkg
module arpc_cell #(
  parameter int INDEX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     age_limit,
  input  arpc_pkg::tok_t tok_in,
  input  arpc_pkg::wr_t  wr,
  output arpc_pkg::tok_t tok_out
);

  logic        ent_valid;
  logic [31:0] ent_ip;
  logic [47:0] ent_mac;
  logic [7:0]  ent_age;

  logic           match;
  logic [8:0]     age_inc;
  logic           expire;
  logic           wr_hit;
  arpc_pkg::tok_t tok_next;

  assign match   = ent_valid && (ent_ip == tok_in.ip);
  assign age_inc = {1'b0, ent_age} + 9'd1;
  assign expire  = age_inc > {1'b0, age_limit};
  assign wr_hit  = wr.en && (wr.slot == arpc_pkg::SLOT_W'(INDEX));

  always_comb begin
    tok_next = tok_in;
    unique case (tok_in.op)
      arpc_pkg::OP_INSERT: begin
        if (match) begin
          tok_next.found = 1'b1;
        end else if (!ent_valid && !tok_in.free_found) begin
          // lowest free slot claims the insert
          tok_next.free_found = 1'b1;
          tok_next.free_slot  = arpc_pkg::SLOT_W'(INDEX);
        end
      end
      arpc_pkg::OP_LOOKUP: begin
        if (match && !tok_in.found) begin
          tok_next.found = 1'b1;
          tok_next.mac   = ent_mac;
        end
      end
      arpc_pkg::OP_TICK: begin
        if (ent_valid && expire && (tok_in.removed != {arpc_pkg::CNT_W{1'b1}})) begin
          tok_next.removed = tok_in.removed + arpc_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid     <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (wr_hit) begin
        ent_valid <= 1'b1;
        ent_ip    <= wr.ip;
        ent_mac   <= wr.mac;
        ent_age   <= 8'd0;
      end else if (tok_in.valid) begin
        unique case (tok_in.op)
          arpc_pkg::OP_LOOKUP: begin
            if (match && !tok_in.found) begin
              ent_age <= 8'd0;
            end
          end
          arpc_pkg::OP_TICK: begin
            if (ent_valid) begin
              if (expire) begin
                ent_valid <= 1'b0;
              end else begin
                ent_age <= age_inc[7:0];
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* rtl/core/arp_cache_with_aging_top.sv */
// arp_cache_with_aging_top: ip to mac cache with per-entry ageing
// depends on arpc_pkg and arpc_cell
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   command  | start / busy         | opcode, ip_address, mac_address
//   result   | done (one cycle)     | outcome, mac_out, removed_count
//   config   | cfg_valid/cfg_ready  | cfg_data (age limit)
//
// an operation token passes one cell per cycle down the row of ENTRIES cells,
// and no new command is accepted until that token has left the row;
// done is registered from the token as it leaves the last cell.
// reset is synchronous: the cache empties at once, no clearing pass.
// the result receiver cannot stall; busy is low again in the done cycle.
// opcode 3 is taken and dropped without a result.
module arp_cache_with_aging_top #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] ip_address,
  input  logic [47:0] mac_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [2:0]  outcome,
  output logic [47:0] mac_out,
  output logic [4:0]  removed_count
);

  logic           accept;
  logic [7:0]     age_limit;
  arpc_pkg::tok_t head;
  arpc_pkg::tok_t chain [ENTRIES+1];
  arpc_pkg::tok_t tail;
  arpc_pkg::wr_t  wr;
  logic [2:0]     outcome_next;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign chain[0]  = head;
  assign tail      = chain[ENTRIES];

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      arpc_cell #(
        .INDEX(gi)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .age_limit(age_limit),
        .tok_in   (chain[gi]),
        .wr       (wr),
        .tok_out  (chain[gi+1])
      );
    end
  endgenerate

  always_comb begin
    wr.en   = tail.valid && (tail.op == arpc_pkg::OP_INSERT) && !tail.found
              && tail.free_found;
    wr.slot = tail.free_slot;
    wr.ip   = tail.ip;
    wr.mac  = tail.mac;
    unique case (tail.op)
      arpc_pkg::OP_INSERT: begin
        if (tail.found) begin
          outcome_next = arpc_pkg::RES_PRESENT;
        end else if (tail.free_found) begin
          outcome_next = arpc_pkg::RES_INSERTED;
        end else begin
          outcome_next = arpc_pkg::RES_FULL;
        end
      end
      arpc_pkg::OP_LOOKUP: begin
        outcome_next = tail.found ? arpc_pkg::RES_HIT : arpc_pkg::RES_MISS;
      end
      default: begin
        outcome_next = arpc_pkg::RES_TICKED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit  <= arpc_pkg::AGE_LIMIT_RST;
      busy       <= 1'b0;
      done       <= 1'b0;
      head.valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        age_limit <= cfg_data;
      end
      head.valid      <= accept && (opcode != arpc_pkg::OP_NONE);
      head.op         <= opcode;
      head.ip         <= ip_address;
      head.mac        <= mac_address;
      head.found      <= 1'b0;
      head.free_found <= 1'b0;
      head.free_slot  <= '0;
      head.removed    <= '0;
      if (accept && (opcode != arpc_pkg::OP_NONE)) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
      done <= tail.valid;
      if (tail.valid) begin
        outcome       <= outcome_next;
        mac_out       <= (tail.op == arpc_pkg::OP_LOOKUP && tail.found) ? tail.mac : 48'd0;
        removed_count <= (tail.op == arpc_pkg::OP_TICK) ? tail.removed : 5'd0;
      end
    end
  end

endmodule

/* rtl/core/arpc_checker.sv */
// arpc_checker: port-level checks on the cache top level, bound in below
// depends on arpc_pkg
module arpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode,
  input logic        done,
  input logic [2:0]  outcome,
  input logic [47:0] mac_out,
  input logic [4:0]  removed_count
);

  // a result frees the command side in the same cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high with result beat");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode != arpc_pkg::OP_NONE)) |=> (busy && !done))
    else $error("command beat did not start work");

  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == arpc_pkg::OP_NONE)) |=> (!busy && !done))
    else $error("unused opcode produced activity");

  a_mac_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome != arpc_pkg::RES_HIT)) |-> (mac_out == 48'd0))
    else $error("mac_out not zero outside a hit");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome != arpc_pkg::RES_TICKED)) |-> (removed_count == 5'd0))
    else $error("removed_count not zero outside a tick");

endmodule

bind arp_cache_with_aging_top arpc_checker u_arpc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .opcode       (opcode),
  .done         (done),
  .outcome      (outcome),
  .mac_out      (mac_out),
  .removed_count(removed_count)
);
